// ----- rtl/irpw_pkg.sv -----
// Package for the IR pulse-width frame sender.
// Holds register indexes, reset values, line phase codes and the config bundle.
// No dependencies.
package irpw_pkg;

    // Register widths and indexes on the APB port
    localparam int unsigned TICK_W = 16;
    localparam int unsigned REP_W  = 2;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [1:0] REG_SHORT  = 2'd0;
    localparam logic [1:0] REG_LONG   = 2'd1;
    localparam logic [1:0] REG_GAP    = 2'd2;
    localparam logic [1:0] REG_REPEAT = 2'd3;

    // Reset values of the registers
    localparam logic [TICK_W-1:0] SHORT_RST  = 16'd800;
    localparam logic [TICK_W-1:0] LONG_RST   = 16'd1600;
    localparam logic [TICK_W-1:0] GAP_RST    = 16'd3000;
    localparam logic [REP_W-1:0]  REPEAT_RST = 2'd2;

    // Line phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_GAP  = 2'd3;

    // Timing settings handed from the register block to the sequencer
    typedef struct packed {
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [REP_W-1:0]  repeat_count;
    } cfg_t;

endpackage

// ----- rtl/irpw_regs.sv -----
// APB register block of the IR pulse-width frame sender.
// Holds short, long, gap tick counts and the repeat count; uses irpw_pkg.
module irpw_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irpw_pkg::ADDR_W-1:0]   paddr,
    input  logic [irpw_pkg::PDATA_W-1:0]  pwdata,
    output logic [irpw_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output irpw_pkg::cfg_t                cfg
);

    irpw_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ticks  <= irpw_pkg::SHORT_RST;
            cfg_reg.long_ticks   <= irpw_pkg::LONG_RST;
            cfg_reg.gap_ticks    <= irpw_pkg::GAP_RST;
            cfg_reg.repeat_count <= irpw_pkg::REPEAT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                irpw_pkg::REG_SHORT:  cfg_reg.short_ticks  <= pwdata[irpw_pkg::TICK_W-1:0];
                irpw_pkg::REG_LONG:   cfg_reg.long_ticks   <= pwdata[irpw_pkg::TICK_W-1:0];
                irpw_pkg::REG_GAP:    cfg_reg.gap_ticks    <= pwdata[irpw_pkg::TICK_W-1:0];
                irpw_pkg::REG_REPEAT: cfg_reg.repeat_count <= pwdata[irpw_pkg::REP_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            irpw_pkg::REG_SHORT:  prdata[irpw_pkg::TICK_W-1:0] = cfg_reg.short_ticks;
            irpw_pkg::REG_LONG:   prdata[irpw_pkg::TICK_W-1:0] = cfg_reg.long_ticks;
            irpw_pkg::REG_GAP:    prdata[irpw_pkg::TICK_W-1:0] = cfg_reg.gap_ticks;
            irpw_pkg::REG_REPEAT: prdata[irpw_pkg::REP_W-1:0]  = cfg_reg.repeat_count;
            default:              prdata = '0;
        endcase
    end

endmodule

// ----- rtl/ir_pulse_width_frame_sender.sv -----
// Top level of the IR pulse-width frame sender: stream in, stream out, APB config.
// Uses irpw_pkg and irpw_regs.
//
//  channel   dir   handshake          payload
//  s_*       in    s_tvalid/s_tready  tuser: kind; tdata: player, data_field, control_field
//  m_*       out   m_tvalid/m_tready  tdata: ir_level, busy_res
//  APB       in    psel/penable       short, long, gap ticks, repeat count
//
// One item per cycle while the output is not stalled: each accepted item updates the
// sequencer state in the same edge and its result lands in the output register.
// s_tready stays high while the output register is empty or being drained,
// so a stalled output holds only the one result.
// Reset clears all state; the line is idle and low after reset.
module ir_pulse_width_frame_sender
#(
    parameter int unsigned FIELD_BITS = 5
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [FIELD_BITS-1:0] player, next data_field, next control_field, zero fill
    input  logic [((3*FIELD_BITS+7)/8)*8-1:0] s_tdata,
    // [0] kind
    input  logic                             s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] ir_level, [1] busy_res, zero fill
    output logic [7:0]                       m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [irpw_pkg::ADDR_W-1:0]      paddr,
    input  logic [irpw_pkg::PDATA_W-1:0]     pwdata,
    output logic [irpw_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int unsigned FRAME_LEN = 1 + 3 * FIELD_BITS;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
    localparam int unsigned TW = irpw_pkg::TICK_W;

    irpw_pkg::cfg_t cfg;

    logic [FRAME_LEN-1:0]  frame_reg, frame_next;
    logic [FRAME_LEN-1:0]  pend_frame_reg, pend_frame_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      bit_idx_reg, bit_idx_next;
    logic [1:0]            phase_reg, phase_next;
    logic [TW-1:0]         tick_cnt_reg, tick_cnt_next;
    logic [1:0]            passes_reg, passes_next;
    logic                  out_valid_reg;
    logic [1:0]            out_data_reg;

    logic                  accept;
    logic [FRAME_LEN-1:0]  fire_frame;
    logic [IDX_W-1:0]      bit_pos;
    logic                  cur_bit;
    logic [TW-1:0]         seg_raw;
    logic [TW-1:0]         seg_len;
    logic [TW-1:0]         tick_inc;
    logic [1:0]            reps;
    logic [1:0]            passes_inc;

    irpw_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

    // Frame: start one, then player, data, control, msb first
    assign fire_frame = {1'b1,
                         s_tdata[FIELD_BITS-1:0],
                         s_tdata[2*FIELD_BITS-1:FIELD_BITS],
                         s_tdata[3*FIELD_BITS-1:2*FIELD_BITS]};

    // Current bit and the length of the running segment
    assign bit_pos = LAST_IDX - bit_idx_reg;
    assign cur_bit = frame_reg[bit_pos];

    always_comb
    begin
        unique case (phase_reg)
            irpw_pkg::PH_HIGH: seg_raw = cur_bit ? cfg.long_ticks : cfg.short_ticks;
            irpw_pkg::PH_LOW:  seg_raw = cur_bit ? cfg.short_ticks : cfg.long_ticks;
            default:           seg_raw = cfg.gap_ticks;
        endcase
    end

    assign seg_len    = (seg_raw == '0) ? TW'(1) : seg_raw;
    assign tick_inc   = tick_cnt_reg + TW'(1);
    assign reps       = (cfg.repeat_count == '0) ? 2'd1 : cfg.repeat_count;
    assign passes_inc = passes_reg + 2'd1;

    // Sequencer next state for one item
    always_comb
    begin
        frame_next      = frame_reg;
        pend_frame_next = pend_frame_reg;
        pend_next       = pend_reg;
        bit_idx_next    = bit_idx_reg;
        phase_next      = phase_reg;
        tick_cnt_next   = tick_cnt_reg;
        passes_next     = passes_reg;

        if (s_tuser)
        begin
            if (phase_reg == irpw_pkg::PH_IDLE)
            begin
                frame_next    = fire_frame;
                bit_idx_next  = '0;
                passes_next   = '0;
                tick_cnt_next = '0;
                phase_next    = irpw_pkg::PH_HIGH;
            end
            else
            begin
                pend_frame_next = fire_frame;
                pend_next       = 1'b1;
            end
        end
        else if (phase_reg != irpw_pkg::PH_IDLE)
        begin
            if (tick_inc != '0 && tick_inc < seg_len)
            begin
                tick_cnt_next = tick_inc;
            end
            else
            begin
                tick_cnt_next = '0;
                priority if (phase_reg == irpw_pkg::PH_HIGH)
                begin
                    phase_next = irpw_pkg::PH_LOW;
                end
                else if (phase_reg == irpw_pkg::PH_LOW && bit_idx_reg != LAST_IDX)
                begin
                    bit_idx_next = bit_idx_reg + IDX_W'(1);
                    phase_next   = irpw_pkg::PH_HIGH;
                end
                else if (phase_reg == irpw_pkg::PH_LOW && cfg.gap_ticks != '0)
                begin
                    phase_next = irpw_pkg::PH_GAP;
                end
                else
                begin
                    // end of a pass: repeat, take the pending frame, or go idle
                    bit_idx_next = '0;
                    if (passes_inc >= reps)
                    begin
                        passes_next = '0;
                        if (pend_reg)
                        begin
                            pend_next  = 1'b0;
                            frame_next = pend_frame_reg;
                            phase_next = irpw_pkg::PH_HIGH;
                        end
                        else
                        begin
                            phase_next = irpw_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        passes_next = passes_inc;
                        phase_next  = irpw_pkg::PH_HIGH;
                    end
                end
            end
        end
    end

    // State update on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg      <= '0;
            pend_frame_reg <= '0;
            pend_reg       <= 1'b0;
            bit_idx_reg    <= '0;
            phase_reg      <= irpw_pkg::PH_IDLE;
            tick_cnt_reg   <= '0;
            passes_reg     <= '0;
        end
        else if (accept)
        begin
            frame_reg      <= frame_next;
            pend_frame_reg <= pend_frame_next;
            pend_reg       <= pend_next;
            bit_idx_reg    <= bit_idx_next;
            phase_reg      <= phase_next;
            tick_cnt_reg   <= tick_cnt_next;
            passes_reg     <= passes_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= {(phase_next != irpw_pkg::PH_IDLE) || pend_next,
                              phase_next == irpw_pkg::PH_HIGH};
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Checks
    a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == irpw_pkg::PH_IDLE) |-> (tick_cnt_reg == '0 && passes_reg == '0))
        else $error("tick or pass count left over while idle");

    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (phase_reg != irpw_pkg::PH_IDLE))
        else $error("pending frame while line idle");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_idx_reg <= LAST_IDX)
        else $error("bit index past end of frame");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !accept)
        else $error("input taken while result stalled");

endmodule

// ----- verif/ir_pulse_width_frame_sender_tb.sv -----
// Testbench for the IR pulse-width frame sender: fire and tick transfers in, line level out.
// Predicts every result in a small scoreboard class and programs the timing over APB.
// Depends on irpw_pkg and ir_pulse_width_frame_sender.
`timescale 1ns / 1ps

module ir_pulse_width_frame_sender_tb;

    localparam int FIELD_BITS = 5;
    localparam int FRAME_LEN  = 1 + 3 * FIELD_BITS;
    localparam int DATA_W     = ((3 * FIELD_BITS + 7) / 8) * 8;

    // Expected line state after one input transfer
    typedef struct packed {
        logic busy;
        logic level;
    } line_state_t;

    // Line sequencer model and expected-result store
    class ir_frame_scoreboard;
        irpw_pkg::cfg_t      timing;
        logic [15:0]         frame_word;
        logic [15:0]         queued_frame;
        logic [15:0]         seg_count;
        logic [3:0]          bit_pos;
        logic [1:0]          line_phase;
        logic [1:0]          passes;
        logic                queued;
        line_state_t         line_expect_q[$];
        int                  mismatches;

        function new();
            timing.short_ticks  = irpw_pkg::SHORT_RST;
            timing.long_ticks   = irpw_pkg::LONG_RST;
            timing.gap_ticks    = irpw_pkg::GAP_RST;
            timing.repeat_count = irpw_pkg::REPEAT_RST;
            frame_word   = '0;
            queued_frame = '0;
            seg_count    = '0;
            bit_pos      = '0;
            line_phase   = irpw_pkg::PH_IDLE;
            passes       = '0;
            queued       = 1'b0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            unique case (idx)
                irpw_pkg::REG_SHORT:  timing.short_ticks  = value[15:0];
                irpw_pkg::REG_LONG:   timing.long_ticks   = value[15:0];
                irpw_pkg::REG_GAP:    timing.gap_ticks    = value[15:0];
                irpw_pkg::REG_REPEAT: timing.repeat_count = value[1:0];
            endcase
        endfunction

        function void load_frame(logic [15:0] word);
            frame_word = word;
            bit_pos    = '0;
            passes     = '0;
            seg_count  = '0;
            line_phase = irpw_pkg::PH_HIGH;
        endfunction

        // End of one pass: repeat, start the latched frame, or go idle
        function void finish_pass();
            logic [1:0] reps;
            reps      = (timing.repeat_count == 0) ? 2'd1 : timing.repeat_count;
            passes    = passes + 2'd1;
            seg_count = '0;
            if (passes >= reps)
            begin
                if (queued)
                begin
                    queued = 1'b0;
                    load_frame(queued_frame);
                end
                else
                begin
                    line_phase = irpw_pkg::PH_IDLE;
                    passes     = '0;
                    bit_pos    = '0;
                end
            end
            else
            begin
                bit_pos    = '0;
                line_phase = irpw_pkg::PH_HIGH;
            end
        endfunction

        // Length of the running segment; zero counts as one tick
        function int unsigned segment_ticks();
            logic        one;
            logic [15:0] len;
            one = frame_word[FRAME_LEN - 1 - bit_pos];
            if (line_phase == irpw_pkg::PH_HIGH)
                len = one ? timing.long_ticks : timing.short_ticks;
            else if (line_phase == irpw_pkg::PH_LOW)
                len = one ? timing.short_ticks : timing.long_ticks;
            else
                len = timing.gap_ticks;
            return (len == 0) ? 1 : int'(len);
        endfunction

        function void advance_tick();
            if (line_phase == irpw_pkg::PH_IDLE)
                return;
            seg_count = seg_count + 16'd1;
            if (seg_count != 0 && int'(seg_count) < segment_ticks())
                return;
            seg_count = '0;
            if (line_phase == irpw_pkg::PH_HIGH)
            begin
                line_phase = irpw_pkg::PH_LOW;
            end
            else if (line_phase == irpw_pkg::PH_LOW)
            begin
                if (int'(bit_pos) + 1 < FRAME_LEN)
                begin
                    bit_pos    = bit_pos + 4'd1;
                    line_phase = irpw_pkg::PH_HIGH;
                end
                else if (timing.gap_ticks == 0)
                begin
                    finish_pass();
                end
                else
                begin
                    line_phase = irpw_pkg::PH_GAP;
                end
            end
            else
            begin
                finish_pass();
            end
        endfunction

        function void note_item(logic fire, logic [4:0] player, logic [4:0] data_f,
                                logic [4:0] ctrl_f);
            line_state_t st;
            logic [15:0] word;
            if (fire)
            begin
                word = {1'b1, player, data_f, ctrl_f};
                if (line_phase == irpw_pkg::PH_IDLE)
                begin
                    load_frame(word);
                end
                else
                begin
                    queued_frame = word;
                    queued       = 1'b1;
                end
            end
            else
            begin
                advance_tick();
            end
            st.level = (line_phase == irpw_pkg::PH_HIGH);
            st.busy  = (line_phase != irpw_pkg::PH_IDLE) || queued;
            line_expect_q.push_back(st);
        endfunction

        function void check_result(logic [7:0] tdata);
            line_state_t want;
            if (line_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result ir_level=%0b busy=%0b",
                             $realtime, tdata[0], tdata[1]);
                return;
            end
            want = line_expect_q.pop_front();
            if (tdata[0] !== want.level || tdata[1] !== want.busy)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch ir_level exp %0b got %0b, busy exp %0b got %0b",
                             $realtime, want.level, tdata[0], want.busy, tdata[1]);
            end
        endfunction

        function int outstanding();
            return line_expect_q.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [DATA_W-1:0]             s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [7:0]                    m_tdata;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [irpw_pkg::ADDR_W-1:0]   paddr;
    logic [irpw_pkg::PDATA_W-1:0]  pwdata;
    logic [irpw_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    ir_frame_scoreboard  sb;
    int                  src_idle_pct;
    int                  sink_stall_pct;

    ir_pulse_width_frame_sender #(.FIELD_BITS(FIELD_BITS)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    always #5 clk = ~clk;

    // Receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: note accepted inputs first, then check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[4:0], s_tdata[9:5], s_tdata[14:10]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic fire, input logic [4:0] player,
                             input logic [4:0] data_f, input logic [4:0] ctrl_f);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fire;
        s_tdata  <= {1'b0, ctrl_f, data_f, player};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(1'b0, 5'($urandom_range(31)), 5'($urandom_range(31)),
                  5'($urandom_range(31)));
    endtask

    task automatic send_random_item();
        logic fire;
        fire = ($urandom_range(39) == 0);
        send_item(fire, 5'($urandom_range(31)), 5'($urandom_range(31)),
                  5'($urandom_range(31)));
    endtask

    // APB write: setup then access, then back to idle; program_timing puts junk in the unused upper bits
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_timing(input logic [15:0] short_t, input logic [15:0] long_t,
                                  input logic [15:0] gap_t, input logic [1:0] reps);
        apb_write(irpw_pkg::REG_SHORT,  {16'($urandom), short_t});
        apb_write(irpw_pkg::REG_LONG,   {16'($urandom), long_t});
        apb_write(irpw_pkg::REG_GAP,    {16'($urandom), gap_t});
        apb_write(irpw_pkg::REG_REPEAT, {30'($urandom), reps});
    endtask

    // Stop the input and let every expected result come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Main sequence
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sb             = new();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero short, zero gap, zero repeat count
        program_timing(16'd0, 16'd2, 16'd0, 2'd0);
        send_item(1'b1, 5'd31, 5'd31, 5'd31);   // fire when idle
        send_item(1'b1, 5'd0, 5'd0, 5'd0);      // fire when busy
        send_item(1'b1, 5'h15, 5'h0A, 5'h15);   // later fire overwrites the latched one
        repeat (20) send_tick();
        wait_for_results();

        // Directed: largest timings and repeat count
        program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
        send_item(1'b1, 5'h0A, 5'h15, 5'h0A);
        repeat (2) send_tick();

        // Random phases with small timings so frames complete
        for (int ph = 0; ph < 3; ph++)
        begin
            wait_for_results();
            program_timing(16'($urandom_range(4)), 16'($urandom_range(6)),
                           16'($urandom_range(5)), 2'($urandom_range(3)));
            unique case (ph)
                0:
                begin
                    src_idle_pct   = 10;
                    sink_stall_pct = 63;
                end
                1:
                begin
                    src_idle_pct   = 63;
                    sink_stall_pct = 10;
                end
                default:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            repeat (130) send_random_item();
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- ir_pulse_width_frame_sender.f -----
rtl/irpw_pkg.sv
rtl/irpw_regs.sv
rtl/ir_pulse_width_frame_sender.sv
verif/ir_pulse_width_frame_sender_tb.sv
